FILE: rtl/dsn_pkg.sv
// Shared types, constants and a helper function for the dataset statistics normaliser.
package dsn_pkg;

  localparam int MaxExamples = 256;
  localparam int ExBits      = $clog2(MaxExamples);
  localparam int TotBits     = ExBits + 1;
  localparam int NumComp     = 32;
  localparam int CompBits    = $clog2(NumComp);
  localparam int StoreDepth  = MaxExamples * NumComp;
  localparam int StoreAw     = ExBits + CompBits;
  localparam int DivW        = 73;
  localparam int DenW        = 33;
  localparam int StepW       = 7;
  localparam int SqrtInW     = 62;
  localparam int SqrtOutW    = 31;
  localparam int SqrtStepW   = 5;
  localparam int SumW        = 32 + TotBits;

  localparam logic [2:0] MODE_ADD     = 3'd0;
  localparam logic [2:0] MODE_COMPUTE = 3'd1;
  localparam logic [2:0] MODE_NORM    = 3'd2;
  localparam logic [2:0] MODE_DENORM  = 3'd3;
  localparam logic [2:0] MODE_CLEAR   = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_FEW  = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  localparam logic [1:0] CFG_NORM_EN = 2'd0;
  localparam logic [1:0] CFG_SCALE   = 2'd1;
  localparam logic [1:0] CFG_DOMAIN  = 2'd2;
  localparam logic [1:0] CFG_CODOM   = 2'd3;

  localparam logic [30:0] StdvOne = 31'd65536;
  localparam logic [30:0] StdvMax = 31'h7FFFFFFF;

  typedef struct packed {
    logic [2:0]         mode;
    logic [4:0]         component;
    logic signed [31:0] sample_value;
    logic               end_of_example;
  } dsn_item_t;

  typedef struct packed {
    logic [4:0]         out_component;
    logic signed [31:0] mean_out;
    logic [30:0]        stdv_out;
    logic signed [31:0] min_out;
    logic signed [31:0] max_out;
    logic signed [31:0] mapped_value;
    logic [1:0]         status;
    logic               last;
  } dsn_result_t;

  typedef struct packed {
    logic signed [31:0] mean;
    logic [30:0]        stdv;
    logic signed [31:0] mn;
    logic signed [31:0] mx;
  } dsn_stats_t;

  typedef struct packed {
    logic              start;
    logic [DivW-1:0]   dividend;
    logic [DenW-1:0]   divisor;
    logic [StepW-1:0]  steps;
  } dsn_div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
  } dsn_div_rsp_t;

  typedef struct packed {
    logic               start;
    logic [SqrtInW-1:0] radicand;
  } dsn_sqrt_req_t;

  typedef struct packed {
    logic                done;
    logic [SqrtOutW-1:0] root;
  } dsn_sqrt_rsp_t;

  function automatic logic [4:0] clamp_count(logic [4:0] c);
    logic [4:0] r;
    r = c;
    if (c == 5'd0) r = 5'd1;
    if (c > 5'd16) r = 5'd16;
    return r;
  endfunction

endpackage

FILE: rtl/dataset_stats_normaliser.sv
// Dataset statistics normaliser: example store, statistics table and the sequencer.
// Add and clear: the result strobes in the cycle after start is taken and busy stays low;
// undefined mode codes give no result. Normalise and un-normalise: the multiply path goes
// through load, multiply, shift and output, zero spread from load to output, and the divide
// path waits on the radix-2 divider. Compute: per component two store passes, a divide for
// the mean and one for the variance, a square root; normalising off sets zero mean, unit spread.
// Reset restores register defaults and empties the statistics; the store stays undefined.
module dataset_stats_normaliser import dsn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  dsn_item_t   item_i,
  output logic        res_valid_o,
  output dsn_result_t res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [4:0]  cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_C_START, S_C_DIS, S_P1, S_MDIV, S_P2, S_SDIV, S_SQRT, S_C_WR,
    S_M_LOAD, S_M_MUL, S_M_SHF, S_M_DIV, S_M_OUT
  } state_e;

  localparam logic signed [67:0] SatHi = 68'sd2147483647;
  localparam logic signed [67:0] SatLo = -68'sd2147483648;

  state_e state_q;

  logic       norm_en_q;
  logic       scale_q;
  logic [4:0] dom_q;
  logic [4:0] cod_q;
  logic [5:0] n_act;

  logic [TotBits-1:0]  total_q;
  logic [TotBits-1:0]  i_q;
  logic [CompBits-1:0] j_q;
  logic                iss_q;
  logic                v2_q;
  logic                v3_q;
  logic                first_q;
  logic                neg_q;

  logic signed [SumW-1:0] sum_q;
  logic signed [31:0]     mean_q;
  logic signed [31:0]     mn_q;
  logic signed [31:0]     mx_q;
  logic [30:0]            stdv_q;
  logic [32:0]            m_q;
  logic [65:0]            sq_q;
  logic [DivW-1:0]        acc_q;

  logic [2:0]         mode_q;
  logic [4:0]         comp_q;
  logic signed [31:0] x_q;
  logic signed [32:0] mul_a_q;
  logic signed [32:0] mul_b_q;
  logic signed [32:0] off_q;
  logic signed [65:0] prod_q;
  logic signed [67:0] fin_q;

  dsn_result_t res_q;
  logic        res_vld_q;

  logic accept;

  logic signed [31:0] store_mem [StoreDepth];
  logic signed [31:0] st_rdata_q;
  logic               st_we;
  logic [StoreAw-1:0] st_waddr;
  logic               st_re;
  logic [StoreAw-1:0] st_raddr;

  dsn_stats_t          stats_mem [NumComp];
  dsn_stats_t          stats_rd_q;
  logic                stats_rvld_q;
  logic [NumComp-1:0]  stats_vld_q;
  logic [CompBits-1:0] sr_addr;
  dsn_stats_t          stat;
  logic                sw_we;
  dsn_stats_t          sw_data;

  dsn_div_req_t  div_req_q;
  dsn_div_rsp_t  div_rsp;
  dsn_sqrt_req_t sqrt_req_q;
  dsn_sqrt_rsp_t sqrt_rsp;

  logic signed [32:0] d33;
  logic [32:0]        d_mag;
  logic [SumW-1:0]    sum_mag;
  logic signed [32:0] m_x;
  logic signed [32:0] m_dm;
  logic signed [32:0] m_dn;
  logic signed [32:0] m_rg;
  logic signed [32:0] m_t;
  logic signed [32:0] m_h;
  logic [32:0]        m_dm_mag;
  logic [32:0]        m_dn_mag;
  logic [32:0]        m_rg_mag;
  logic [32:0]        m_t_mag;
  logic [32:0]        m_h_mag;
  logic [65:0]        prod_mag;
  logic [49:0]        prod_q16;
  logic               c_last;
  logic [1:0]         c_status;

  dsn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  dsn_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req_q),
    .rsp_o  (sqrt_rsp)
  );

  assign n_act  = {1'b0, clamp_count(dom_q)} + {1'b0, clamp_count(cod_q)};
  assign busy   = (state_q != S_IDLE);
  assign accept = start && (state_q == S_IDLE);

  assign st_we    = accept && (item_i.mode == MODE_ADD) && (total_q < TotBits'(MaxExamples))
                    && ({1'b0, item_i.component} < n_act);
  assign st_waddr = {total_q[ExBits-1:0], item_i.component};
  assign st_re    = ((state_q == S_P1) || (state_q == S_P2)) && (i_q < total_q);
  assign st_raddr = {i_q[ExBits-1:0], j_q};

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[st_waddr] <= item_i.sample_value;
    end
    if (st_re) begin
      st_rdata_q <= store_mem[st_raddr];
    end
  end

  assign sr_addr = (state_q == S_IDLE) ? item_i.component : j_q;
  assign sw_we   = (state_q == S_C_WR) || (state_q == S_C_DIS);
  assign stat    = stats_rvld_q ? stats_rd_q : '0;

  always_comb begin
    if (state_q == S_C_DIS) begin
      sw_data      = stat;
      sw_data.mean = '0;
      sw_data.stdv = StdvOne;
    end else begin
      sw_data.mean = mean_q;
      sw_data.stdv = stdv_q;
      sw_data.mn   = mn_q;
      sw_data.mx   = mx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sw_we) begin
      stats_mem[j_q] <= sw_data;
    end
    stats_rd_q <= stats_mem[sr_addr];
  end

  always_comb begin
    d33      = 33'(st_rdata_q) - 33'(mean_q);
    d_mag    = d33[32] ? 33'(-d33) : 33'(d33);
    sum_mag  = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
    m_x      = 33'(x_q);
    m_dm     = m_x - 33'(stat.mean);
    m_dn     = m_x - 33'(stat.mn);
    m_rg     = 33'(stat.mx) - 33'(stat.mn);
    m_t      = m_x + 33'sd65536;
    m_dm_mag = m_dm[32] ? 33'(-m_dm) : 33'(m_dm);
    m_dn_mag = m_dn[32] ? 33'(-m_dn) : 33'(m_dn);
    m_rg_mag = m_rg[32] ? 33'(-m_rg) : 33'(m_rg);
    m_t_mag  = m_t[32] ? 33'(-m_t) : 33'(m_t);
    m_h_mag  = m_t_mag >> 1;
    m_h      = m_t[32] ? -$signed(m_h_mag) : $signed(m_h_mag);
    prod_mag = prod_q[65] ? 66'(-prod_q) : 66'(prod_q);
    prod_q16 = prod_mag[65:16];
    c_last   = (6'(j_q) + 6'd1) == n_act;
    if (total_q < TotBits'(2)) begin
      c_status = ST_FEW;
    end else if (stdv_q == StdvMax) begin
      c_status = ST_SAT;
    end else begin
      c_status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_en_q <= 1'b1;
      scale_q   <= 1'b0;
      dom_q     <= 5'd16;
      cod_q     <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NORM_EN: norm_en_q <= cfg_data_i[0];
        CFG_SCALE:   scale_q   <= cfg_data_i[0];
        CFG_DOMAIN:  dom_q     <= cfg_data_i;
        CFG_CODOM:   cod_q     <= cfg_data_i;
        default:     norm_en_q <= norm_en_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      total_q      <= '0;
      i_q          <= '0;
      j_q          <= '0;
      iss_q        <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      first_q      <= 1'b0;
      neg_q        <= 1'b0;
      sum_q        <= '0;
      mean_q       <= '0;
      mn_q         <= '0;
      mx_q         <= '0;
      stdv_q       <= '0;
      m_q          <= '0;
      sq_q         <= '0;
      acc_q        <= '0;
      mode_q       <= '0;
      comp_q       <= '0;
      x_q          <= '0;
      mul_a_q      <= '0;
      mul_b_q      <= '0;
      off_q        <= '0;
      prod_q       <= '0;
      fin_q        <= '0;
      res_q        <= '0;
      res_vld_q    <= 1'b0;
      stats_vld_q  <= '0;
      stats_rvld_q <= 1'b0;
      div_req_q    <= '0;
      sqrt_req_q   <= '0;
    end else begin
      res_vld_q        <= 1'b0;
      div_req_q.start  <= 1'b0;
      sqrt_req_q.start <= 1'b0;
      stats_rvld_q     <= stats_vld_q[sr_addr];
      if (sw_we) begin
        stats_vld_q[j_q] <= 1'b1;
      end
      iss_q <= st_re;
      if (st_re) begin
        i_q <= i_q + 1'b1;
      end
      v2_q <= iss_q;
      v3_q <= v2_q;
      m_q  <= d_mag;
      sq_q <= m_q * m_q;

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            mode_q <= item_i.mode;
            comp_q <= item_i.component;
            x_q    <= item_i.sample_value;
            res_q  <= '0;
            case (item_i.mode)
              MODE_ADD: begin
                res_vld_q           <= 1'b1;
                res_q.out_component <= item_i.component;
                res_q.last          <= 1'b1;
                if (total_q >= TotBits'(MaxExamples)) begin
                  res_q.status <= ST_FULL;
                end else if (item_i.end_of_example) begin
                  total_q <= total_q + 1'b1;
                end
              end
              MODE_COMPUTE: begin
                j_q     <= '0;
                state_q <= S_C_START;
              end
              MODE_NORM, MODE_DENORM: begin
                state_q <= S_M_LOAD;
              end
              MODE_CLEAR: begin
                total_q    <= '0;
                res_vld_q  <= 1'b1;
                res_q.last <= 1'b1;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end

        S_C_START: begin
          if (!norm_en_q) begin
            state_q <= S_C_DIS;
          end else begin
            i_q     <= '0;
            sum_q   <= '0;
            mn_q    <= '0;
            mx_q    <= '0;
            mean_q  <= '0;
            stdv_q  <= '0;
            first_q <= 1'b1;
            state_q <= S_P1;
          end
        end

        S_C_DIS: begin
          res_vld_q <= 1'b1;
          res_q     <= '0;
          res_q.out_component <= j_q;
          res_q.stdv_out      <= StdvOne;
          res_q.min_out       <= stat.mn;
          res_q.max_out       <= stat.mx;
          res_q.last          <= c_last;
          j_q     <= j_q + 1'b1;
          state_q <= c_last ? S_IDLE : S_C_START;
        end

        S_P1: begin
          if (iss_q) begin
            sum_q   <= sum_q + SumW'(st_rdata_q);
            first_q <= 1'b0;
            if (first_q || (st_rdata_q < mn_q)) begin
              mn_q <= st_rdata_q;
            end
            if (first_q || (st_rdata_q > mx_q)) begin
              mx_q <= st_rdata_q;
            end
          end else if (i_q == total_q) begin
            if (total_q == '0) begin
              state_q <= S_C_WR;
            end else begin
              neg_q              <= sum_q[SumW-1];
              div_req_q.start    <= 1'b1;
              div_req_q.dividend <= {sum_mag, (DivW - SumW)'(0)};
              div_req_q.divisor  <= DenW'(total_q);
              div_req_q.steps    <= StepW'(SumW);
              state_q            <= S_MDIV;
            end
          end
        end

        S_MDIV: begin
          if (div_rsp.done) begin
            mean_q <= neg_q ? -div_rsp.quot[31:0] : div_rsp.quot[31:0];
            if (total_q < TotBits'(2)) begin
              state_q <= S_C_WR;
            end else begin
              i_q     <= '0;
              acc_q   <= '0;
              state_q <= S_P2;
            end
          end
        end

        S_P2: begin
          if (v3_q) begin
            acc_q <= acc_q + DivW'(sq_q);
          end
          if (!iss_q && !v2_q && !v3_q && (i_q == total_q)) begin
            div_req_q.start    <= 1'b1;
            div_req_q.dividend <= acc_q;
            div_req_q.divisor  <= DenW'(total_q - 1'b1);
            div_req_q.steps    <= StepW'(DivW);
            state_q            <= S_SDIV;
          end
        end

        S_SDIV: begin
          if (div_rsp.done) begin
            if (|div_rsp.quot[DivW-1:SqrtInW]) begin
              stdv_q  <= StdvMax;
              state_q <= S_C_WR;
            end else begin
              sqrt_req_q.start    <= 1'b1;
              sqrt_req_q.radicand <= div_rsp.quot[SqrtInW-1:0];
              state_q             <= S_SQRT;
            end
          end
        end

        S_SQRT: begin
          if (sqrt_rsp.done) begin
            stdv_q  <= sqrt_rsp.root;
            state_q <= S_C_WR;
          end
        end

        S_C_WR: begin
          res_vld_q           <= 1'b1;
          res_q               <= '0;
          res_q.out_component <= j_q;
          res_q.mean_out      <= mean_q;
          res_q.stdv_out      <= stdv_q;
          res_q.min_out       <= mn_q;
          res_q.max_out       <= mx_q;
          res_q.status        <= c_status;
          res_q.last          <= c_last;
          j_q     <= j_q + 1'b1;
          state_q <= c_last ? S_IDLE : S_C_START;
        end

        S_M_LOAD: begin
          if (!scale_q && (mode_q == MODE_NORM)) begin
            if (stat.stdv != '0) begin
              neg_q              <= m_dm[32];
              off_q              <= '0;
              div_req_q.start    <= 1'b1;
              div_req_q.dividend <= {m_dm_mag, 40'd0};
              div_req_q.divisor  <= {2'b00, stat.stdv};
              div_req_q.steps    <= StepW'(49);
              state_q            <= S_M_DIV;
            end else begin
              fin_q   <= 68'(m_dm);
              state_q <= S_M_OUT;
            end
          end else if (!scale_q) begin
            if (stat.stdv != '0) begin
              mul_a_q <= m_x;
              mul_b_q <= $signed({2'b00, stat.stdv});
              off_q   <= 33'(stat.mean);
              state_q <= S_M_MUL;
            end else begin
              fin_q   <= 68'(m_x) + 68'(stat.mean);
              state_q <= S_M_OUT;
            end
          end else if (mode_q == MODE_NORM) begin
            if (m_rg != '0) begin
              neg_q              <= m_dn[32] ^ m_rg[32];
              off_q              <= -33'sd65536;
              div_req_q.start    <= 1'b1;
              div_req_q.dividend <= {m_dn_mag, 40'd0};
              div_req_q.divisor  <= m_rg_mag;
              div_req_q.steps    <= StepW'(50);
              state_q            <= S_M_DIV;
            end else begin
              fin_q   <= 68'(m_dn);
              state_q <= S_M_OUT;
            end
          end else begin
            if (m_rg != '0) begin
              mul_a_q <= m_h;
              mul_b_q <= m_rg;
              off_q   <= 33'(stat.mn);
              state_q <= S_M_MUL;
            end else begin
              fin_q   <= 68'(m_h) + 68'(stat.mn);
              state_q <= S_M_OUT;
            end
          end
        end

        S_M_MUL: begin
          prod_q  <= mul_a_q * mul_b_q;
          state_q <= S_M_SHF;
        end

        S_M_SHF: begin
          fin_q   <= (prod_q[65] ? -68'(prod_q16) : 68'(prod_q16)) + 68'(off_q);
          state_q <= S_M_OUT;
        end

        S_M_DIV: begin
          if (div_rsp.done) begin
            fin_q   <= (neg_q ? -68'(div_rsp.quot) : 68'(div_rsp.quot)) + 68'(off_q);
            state_q <= S_M_OUT;
          end
        end

        S_M_OUT: begin
          res_vld_q           <= 1'b1;
          res_q               <= '0;
          res_q.out_component <= comp_q;
          res_q.last          <= 1'b1;
          if (fin_q > SatHi) begin
            res_q.mapped_value <= 32'sh7FFFFFFF;
            res_q.status       <= ST_SAT;
          end else if (fin_q < SatLo) begin
            res_q.mapped_value <= 32'sh80000000;
            res_q.status       <= ST_SAT;
          end else begin
            res_q.mapped_value <= fin_q[31:0];
          end
          state_q <= S_IDLE;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/dsn_div.sv
// Radix-2 restoring unsigned divider with a left-aligned dividend and a variable step count.
module dsn_div import dsn_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  dsn_div_req_t req_i,
  output dsn_div_rsp_t rsp_o
);

  logic             run_q;
  logic             done_q;
  logic [StepW-1:0] cnt_q;
  logic [DivW-1:0]  num_q;
  logic [DivW-1:0]  quot_q;
  logic [DenW-1:0]  den_q;
  logic [DenW-1:0]  rem_q;
  logic [DenW:0]    rem_sh;
  logic [DenW:0]    rem_sub;
  logic             fits;

  always_comb begin
    rem_sh  = {rem_q, num_q[DivW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    fits    = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      quot_q <= '0;
      den_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        num_q  <= req_i.dividend;
        den_q  <= req_i.divisor;
        rem_q  <= '0;
        quot_q <= '0;
        cnt_q  <= req_i.steps;
        run_q  <= 1'b1;
      end else if (run_q) begin
        num_q  <= {num_q[DivW-2:0], 1'b0};
        quot_q <= {quot_q[DivW-2:0], fits};
        rem_q  <= fits ? rem_sub[DenW-1:0] : rem_sh[DenW-1:0];
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == StepW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

FILE: rtl/dsn_isqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
module dsn_isqrt import dsn_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dsn_sqrt_req_t req_i,
  output dsn_sqrt_rsp_t rsp_o
);

  logic                 run_q;
  logic                 done_q;
  logic [SqrtStepW-1:0] cnt_q;
  logic [SqrtInW-1:0]   rad_q;
  logic [SqrtOutW-1:0]  res_q;
  logic [SqrtOutW+1:0]  rem_q;
  logic [SqrtOutW+3:0]  rem_sh;
  logic [SqrtOutW+3:0]  trial;
  logic [SqrtOutW+3:0]  rem_dif;
  logic                 fits;

  always_comb begin
    rem_sh  = {rem_q, rad_q[SqrtInW-1:SqrtInW-2]};
    trial   = {2'b00, res_q, 2'b01};
    rem_dif = rem_sh - trial;
    fits    = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rad_q  <= '0;
      res_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rad_q <= req_i.radicand;
        res_q <= '0;
        rem_q <= '0;
        cnt_q <= SqrtStepW'(SqrtOutW);
        run_q <= 1'b1;
      end else if (run_q) begin
        rad_q <= {rad_q[SqrtInW-3:0], 2'b00};
        res_q <= {res_q[SqrtOutW-2:0], fits};
        rem_q <= fits ? rem_dif[SqrtOutW+1:0] : rem_sh[SqrtOutW+1:0];
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == SqrtStepW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = res_q;

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the dataset statistics normaliser.
`timescale 1ns / 100ps

module testbench;
  import dsn_pkg::*;

  localparam int ClkPeriod  = 12;
  localparam int RandTarget = 20;
  localparam int DrainWait  = 20;
  localparam longint CycleLimit = 3000000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  dsn_item_t   item_i;
  logic        res_valid_o;
  dsn_result_t res_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [4:0]  cfg_data_i;

  dataset_stats_normaliser DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .res_valid_o(res_valid_o), .res_o(res_o), .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // Mirror of the block's state.
  int          sample_mem [MaxExamples][NumComp];
  bit          sample_written [MaxExamples][NumComp];
  int          closed_examples;
  int          stat_mean [NumComp];
  int unsigned stat_stdv [NumComp];
  int          stat_min [NumComp];
  int          stat_max [NumComp];
  bit          norm_on;
  bit          range_scaling;
  logic [4:0]  dom_reg;
  logic [4:0]  codom_reg;

  dsn_result_t pending_results [$];
  int          error_count;
  longint      cycle_count;
  int          beats_sent;
  int          beats_checked;
  int          compute_runs;
  bit          steady_sender;

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic int active_components();
    int d;
    int c;
    d = (dom_reg == 0) ? 1 : (dom_reg > 16) ? 16 : int'(dom_reg);
    c = (codom_reg == 0) ? 1 : (codom_reg > 16) ? 16 : int'(codom_reg);
    return (d + c > NumComp) ? NumComp : d + c;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  task automatic refresh_component_stats(int j);
    longint sum;
    longint avg;
    longint mn;
    longint mx;
    longint x;
    longint d;
    logic [63:0] mag;
    logic [79:0] sq_acc;
    logic [79:0] quo;
    sum = 0;
    avg = 0;
    mn = 0;
    mx = 0;
    sq_acc = '0;
    for (int i = 0; i < closed_examples; i++) sum += sample_mem[i][j];
    if (closed_examples > 0) avg = sum / longint'(closed_examples);
    for (int i = 0; i < closed_examples; i++) begin
      x = sample_mem[i][j];
      d = x - avg;
      mag = (d < 0) ? 64'(-d) : 64'(d);
      sq_acc += 80'(mag) * 80'(mag);
      if (i == 0 || x < mn) mn = x;
      if (i == 0 || x > mx) mx = x;
    end
    stat_mean[j] = int'(avg);
    stat_min[j]  = int'(mn);
    stat_max[j]  = int'(mx);
    if (closed_examples < 2) begin
      stat_stdv[j] = 0;
    end else begin
      quo = sq_acc / 80'(closed_examples - 1);
      if (quo >= (80'd1 << 62)) stat_stdv[j] = 32'h7FFF_FFFF;
      else stat_stdv[j] = int'(int_sqrt(quo[63:0]));
    end
  endtask

  task automatic predict_results(dsn_item_t it);
    dsn_result_t r;
    int n;
    longint x;
    longint mean;
    longint stdv;
    longint mn;
    longint mx;
    longint span;
    longint v;
    n = active_components();
    x = it.sample_value;
    r = '0;
    r.last = 1'b1;
    case (it.mode)
      MODE_ADD: begin
        r.out_component = it.component;
        if (closed_examples >= MaxExamples) begin
          r.status = ST_FULL;
        end else begin
          r.status = ST_OK;
          if (it.component < n) begin
            sample_mem[closed_examples][it.component] = it.sample_value;
            sample_written[closed_examples][it.component] = 1'b1;
          end
          if (it.end_of_example) closed_examples++;
        end
        pending_results.push_back(r);
      end
      MODE_COMPUTE: begin
        compute_runs++;
        for (int j = 0; j < n; j++) begin
          r = '0;
          r.status = ST_OK;
          if (!norm_on) begin
            stat_mean[j] = 0;
            stat_stdv[j] = 65536;
          end else begin
            refresh_component_stats(j);
            if (closed_examples < 2) r.status = ST_FEW;
            else if (stat_stdv[j] == 32'h7FFF_FFFF) r.status = ST_SAT;
          end
          r.out_component = 5'(j);
          r.mean_out = stat_mean[j];
          r.stdv_out = stat_stdv[j][30:0];
          r.min_out  = stat_min[j];
          r.max_out  = stat_max[j];
          r.last = (j == n - 1);
          pending_results.push_back(r);
        end
      end
      MODE_NORM, MODE_DENORM: begin
        mean = stat_mean[it.component];
        stdv = stat_stdv[it.component];
        mn   = stat_min[it.component];
        mx   = stat_max[it.component];
        if (!range_scaling) begin
          if (it.mode == MODE_NORM) begin
            v = x - mean;
            if (stdv != 0) v = (v * 65536) / stdv;
          end else begin
            v = x;
            if (stdv != 0) v = (x * stdv) / 65536;
            v += mean;
          end
        end else begin
          span = mx - mn;
          if (it.mode == MODE_NORM) begin
            v = x - mn;
            if (span != 0) v = (v * 2 * 65536) / span - 65536;
          end else begin
            v = (x + 65536) / 2;
            if (span != 0) v = (v * span) / 65536;
            v += mn;
          end
        end
        r.status = ST_OK;
        if (v > 64'sd2147483647) begin
          v = 64'sd2147483647;
          r.status = ST_SAT;
        end else if (v < -64'sd2147483648) begin
          v = -64'sd2147483648;
          r.status = ST_SAT;
        end
        r.out_component = it.component;
        r.mapped_value = v[31:0];
        pending_results.push_back(r);
      end
      MODE_CLEAR: begin
        closed_examples = 0;
        r.status = ST_OK;
        pending_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Sends one item; returns at the edge where it is accepted, with start still high.
  task automatic send_item(logic [2:0] mode, logic [4:0] comp, logic [31:0] value, bit eoe);
    dsn_item_t it;
    int gap;
    it.mode = mode;
    it.component = comp;
    it.sample_value = value;
    it.end_of_example = eoe;
    if (!steady_sender && $urandom_range(99) < 18) begin
      gap = $urandom_range(1, 2);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    predict_results(it);
    beats_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_config(bit ne, bit sm, logic [4:0] dc, logic [4:0] cc);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_NORM_EN;
    cfg_data_i <= {4'($urandom), ne};
    @(posedge clk_i);
    cfg_idx_i <= CFG_SCALE;
    cfg_data_i <= {4'($urandom), sm};
    @(posedge clk_i);
    cfg_idx_i <= CFG_DOMAIN;
    cfg_data_i <= dc;
    @(posedge clk_i);
    cfg_idx_i <= CFG_CODOM;
    cfg_data_i <= cc;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    norm_on = ne;
    range_scaling = sm;
    dom_reg = dc;
    codom_reg = cc;
  endtask

  function automatic bit store_ready();
    for (int i = 0; i < closed_examples; i++)
      for (int j = 0; j < active_components(); j++)
        if (!sample_written[i][j]) return 1'b0;
    return 1'b1;
  endfunction

  // One example with every active component written in random order, with stray items mixed in when noisy.
  task automatic add_example(bit noisy);
    int n;
    int order [$];
    int k;
    logic [31:0] val;
    n = active_components();
    for (int j = 0; j < n; j++) order.push_back(j);
    order.shuffle();
    foreach (order[k0]) begin
      if (noisy && $urandom_range(9) == 0)
        send_item(3'($urandom_range(5, 7)), 5'($urandom), $urandom, 1'($urandom));
      if (noisy && n < NumComp && $urandom_range(7) == 0)
        send_item(MODE_ADD, 5'($urandom_range(n, NumComp - 1)), $urandom, 1'b0);
      k = $urandom_range(3);
      val = (k == 0) ? $urandom : (k == 1) ? 32'($signed($urandom_range(0, 20000000)) - 10000000)
          : (k == 2) ? 32'($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000)
          : 32'($urandom_range(0, 400000));
      send_item(MODE_ADD, 5'(order[k0]), val, k0 == n - 1);
    end
  endtask

  task automatic map_queries(int count);
    logic [2:0] mode;
    for (int q = 0; q < count; q++) begin
      mode = $urandom_range(1) ? MODE_NORM : MODE_DENORM;
      send_item(mode, 5'($urandom), $urandom_range(1) ? $urandom : $urandom_range(0, 300000),
                1'($urandom));
    end
  endtask

  task automatic test_empty_store();
    send_item(MODE_COMPUTE, 5'd0, 32'd0, 1'b0);
    send_item(MODE_NORM, 5'd31, 32'h7FFF_FFFF, 1'b1);
    send_item(MODE_DENORM, 5'd0, 32'h8000_0000, 1'b0);
    send_item(3'd7, 5'd31, 32'hFFFF_FFFF, 1'b1);
    send_item(3'd5, 5'd0, 32'd0, 1'b0);
  endtask

  task automatic test_single_example();
    set_config(1'b1, 1'b0, 5'd1, 5'd1);
    send_item(MODE_CLEAR, 5'd3, 32'd5, 1'b1);
    send_item(MODE_ADD, 5'd0, 32'd65536, 1'b0);
    send_item(MODE_ADD, 5'd1, 32'hFFFF_0000, 1'b1);
    send_item(MODE_COMPUTE, 5'd0, 32'd0, 1'b0);
  endtask

  task automatic test_stdv_overflow();
    send_item(MODE_CLEAR, 5'd0, 32'd0, 1'b0);
    send_item(MODE_ADD, 5'd0, 32'h8000_0000, 1'b0);
    send_item(MODE_ADD, 5'd31, 32'h1234_5678, 1'b0);
    send_item(MODE_ADD, 5'd1, 32'h7FFF_FFFF, 1'b1);
    send_item(MODE_ADD, 5'd1, 32'h8000_0000, 1'b0);
    send_item(MODE_ADD, 5'd0, 32'h7FFF_FFFF, 1'b1);
    send_item(MODE_COMPUTE, 5'd0, 32'd0, 1'b0);
    map_queries(4);
    set_config(1'b1, 1'b1, 5'd1, 5'd1);
    send_item(MODE_NORM, 5'd0, 32'h7FFF_FFFF, 1'b0);
    send_item(MODE_DENORM, 5'd1, 32'h8000_0000, 1'b0);
    map_queries(3);
  endtask

  task automatic test_norm_disabled();
    set_config(1'b0, 1'b0, 5'd0, 5'd31);
    send_item(MODE_COMPUTE, 5'd0, 32'd0, 1'b0);
    map_queries(3);
  endtask

  task automatic test_store_full();
    set_config(1'b1, 1'b0, 5'd1, 5'd1);
    steady_sender = 1'b1;
    send_item(MODE_CLEAR, 5'd0, 32'd0, 1'b0);
    for (int i = 0; i < MaxExamples + 3; i++)
      send_item(MODE_ADD, 5'd0, $urandom, 1'b1);
    send_item(MODE_CLEAR, 5'd0, 32'd0, 1'b0);
    steady_sender = 1'b0;
  endtask

  function automatic logic [4:0] pick_count();
    case ($urandom_range(5))
      0: return 5'd0;
      1: return 5'd31;
      2: return 5'd16;
      3: return 5'd1;
      default: return 5'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic test_random_datasets();
    int start_beats;
    int examples;
    start_beats = beats_sent;
    while (beats_sent - start_beats < RandTarget) begin
      set_config(($urandom_range(3) != 0), 1'($urandom), pick_count(), pick_count());
      steady_sender = ($urandom_range(4) == 0);
      send_item(MODE_CLEAR, 5'($urandom), $urandom, 1'($urandom));
      examples = $urandom_range(0, 5);
      for (int e = 0; e < examples; e++) begin
        if (beats_sent - start_beats >= RandTarget) break;
        if ($urandom_range(11) == 0)
          send_item(MODE_ADD, 5'($urandom_range(0, active_components() - 1)), $urandom, 1'b1);
        else
          add_example(1'b1);
      end
      if (store_ready()) send_item(MODE_COMPUTE, 5'($urandom), $urandom, 1'($urandom));
      map_queries($urandom_range(2, 8));
      steady_sender = 1'b0;
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    dsn_result_t exp_r;
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat for component %0d", res_o.out_component);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("out_component", exp_r.out_component, res_o.out_component);
        check_field("mean_out", exp_r.mean_out, res_o.mean_out);
        check_field("stdv_out", exp_r.stdv_out, res_o.stdv_out);
        check_field("min_out", exp_r.min_out, res_o.min_out);
        check_field("max_out", exp_r.max_out, res_o.max_out);
        check_field("mapped_value", exp_r.mapped_value, res_o.mapped_value);
        check_field("status", exp_r.status, res_o.status);
        check_field("last", exp_r.last, res_o.last);
        beats_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    start <= 1'b0;
    item_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    rst_ni <= 1'b0;
    error_count = 0;
    cycle_count = 0;
    beats_sent = 0;
    beats_checked = 0;
    compute_runs = 0;
    steady_sender = 1'b0;
    closed_examples = 0;
    norm_on = 1'b1;
    range_scaling = 1'b0;
    dom_reg = 5'd16;
    codom_reg = 5'd16;
    for (int j = 0; j < NumComp; j++) begin
      stat_mean[j] = 0;
      stat_stdv[j] = 0;
      stat_min[j] = 0;
      stat_max[j] = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_store();
    test_single_example();
    test_stdv_overflow();
    test_norm_disabled();
    test_store_full();
    test_random_datasets();
    drain();
    $display("Sent %0d input beats, checked %0d result beats over %0d statistics passes.",
             beats_sent, beats_checked, compute_runs);
    $display("Covered empty, single and full stores, spread overflow, both scalings.");
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dsn_pkg.sv
rtl/dsn_div.sv
rtl/dsn_isqrt.sv
rtl/dataset_stats_normaliser.sv
test/testbench.sv
